### sv/allocation_tracker_macros.svh
// Assertion macros used by the allocation tracker checker.
`ifndef ALLOCATION_TRACKER_MACROS_SVH
`define ALLOCATION_TRACKER_MACROS_SVH

// Checked property, masked while reset is asserted.
`define ALCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("allocation tracker check failed");

// Checked property that also holds around reset.
`define ALCT_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("allocation tracker reset check failed");

`endif

### sv/alct_pkg.sv
// Types, codes and helpers for the allocation tracker.
package alct_pkg;

    localparam int unsigned DEF_ENTRIES = 16;
    localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_NEW         = 3'd0,
        STAT_REUSED      = 3'd1,
        STAT_FREED       = 3'd2,
        STAT_NULL_FREE   = 3'd3,
        STAT_DOUBLE_FREE = 3'd4,
        STAT_UNKNOWN     = 3'd5,
        STAT_FULL        = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] address;
        logic [31:0] size;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  entry_index;
        logic [31:0] alloc_count;
        logic [31:0] free_ok_count;
        logic [31:0] free_fail_count;
        logic [31:0] bytes_allocated;
        logic [31:0] bytes_freed;
    } t_out_item;

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? CNT_MAX : s[31:0];
    endfunction

endpackage

### sv/allocation_tracker.sv
// Allocation tracker: slot table with sequential address search and saturating counters.
//
// Each item is searched against the occupied slots one slot per cycle through the
// single read port of the slot memory, lowest index first; the search ends on the
// first hit or after the last occupied slot. The result is held in an output
// register; a new item can be accepted while it waits, but that item's update
// stalls until the previous result is taken. Slot live flags are cleared by
// reset; no clearing pass is needed.
module allocation_tracker #(
    parameter int unsigned ENTRIES = alct_pkg::DEF_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  alct_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alct_pkg::t_out_item o_out_item
);
    import alct_pkg::*;

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    // Control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_scan, n_scan;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_pend_idx, n_pend_idx;
    logic               r_hit, n_hit;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;
    logic [31:0]        r_hit_size, n_hit_size;
    logic [CW-1:0]      r_used, n_used;
    logic [ENTRIES-1:0] r_live, n_live;
    logic [31:0]        r_alloc_cnt, n_alloc_cnt;
    logic [31:0]        r_ok_cnt, n_ok_cnt;
    logic [31:0]        r_fail_cnt, n_fail_cnt;
    logic [31:0]        r_bytes_out, n_bytes_out;
    logic [31:0]        r_bytes_back, n_bytes_back;
    logic               r_out_valid, n_out_valid;

    // Payload
    t_in_item           r_item, n_item;
    t_out_item          r_out, n_out;

    // Slot memory
    logic [31:0]        r_slot_addr [ENTRIES];
    logic [31:0]        r_slot_size [ENTRIES];
    logic [31:0]        r_rd_addr;
    logic [31:0]        r_rd_size;
    logic               mem_we;
    logic [IW-1:0]      mem_wa;

    // Memory: one write port, one registered read port at the scan pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_addr[mem_wa] <= r_item.address;
            r_slot_size[mem_wa] <= r_item.size;
        end
        r_rd_addr <= r_slot_addr[r_scan[IW-1:0]];
        r_rd_size <= r_slot_size[r_scan[IW-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scan       <= '0;
            r_pend       <= 1'b0;
            r_pend_idx   <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
            r_used       <= '0;
            r_live       <= '0;
            r_alloc_cnt  <= '0;
            r_ok_cnt     <= '0;
            r_fail_cnt   <= '0;
            r_bytes_out  <= '0;
            r_bytes_back <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan       <= n_scan;
            r_pend       <= n_pend;
            r_pend_idx   <= n_pend_idx;
            r_hit        <= n_hit;
            r_hit_idx    <= n_hit_idx;
            r_used       <= n_used;
            r_live       <= n_live;
            r_alloc_cnt  <= n_alloc_cnt;
            r_ok_cnt     <= n_ok_cnt;
            r_fail_cnt   <= n_fail_cnt;
            r_bytes_out  <= n_bytes_out;
            r_bytes_back <= n_bytes_back;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_out      <= n_out;
        r_hit_size <= n_hit_size;
    end

    // Sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_size   = r_hit_size;
        n_used       = r_used;
        n_live       = r_live;
        n_alloc_cnt  = r_alloc_cnt;
        n_ok_cnt     = r_ok_cnt;
        n_fail_cnt   = r_fail_cnt;
        n_bytes_out  = r_bytes_out;
        n_bytes_back = r_bytes_back;
        n_item       = r_item;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        mem_we       = 1'b0;
        mem_wa       = r_hit_idx;

        // Result taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_scan  = '0;
                    n_pend  = 1'b0;
                    n_state = S_SEARCH;
                end
            end

            // One slot read issued per cycle, compared in the cycle after
            S_SEARCH: begin
                if (r_pend && (r_rd_addr == r_item.address)) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_pend_idx;
                    n_hit_size = r_rd_size;
                    n_pend     = 1'b0;
                    n_state    = S_UPDATE;
                end else if (r_scan < r_used) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_scan[IW-1:0];
                    n_scan     = r_scan + CW'(1);
                end else begin
                    n_hit   = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_UPDATE;
                end
            end

            // Apply the update once the output register is free
            S_UPDATE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.entry_index = '0;
                    if (r_item.command == CMD_ALLOC) begin
                        if (r_hit) begin
                            mem_we                 = 1'b1;
                            mem_wa                 = r_hit_idx;
                            n_live[r_hit_idx]      = 1'b1;
                            n_out.status           = STAT_REUSED;
                            n_out.entry_index      = 4'(r_hit_idx);
                        end else if (r_used == CW'(ENTRIES)) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            mem_we                 = 1'b1;
                            mem_wa                 = r_used[IW-1:0];
                            n_live[r_used[IW-1:0]] = 1'b1;
                            n_used                 = r_used + CW'(1);
                            n_alloc_cnt            = sat_add(r_alloc_cnt, 32'd1);
                            n_bytes_out            = sat_add(r_bytes_out, r_item.size);
                            n_out.status           = STAT_NEW;
                            n_out.entry_index      = 4'(r_used[IW-1:0]);
                        end
                    end else begin
                        if (r_item.address == '0) begin
                            n_fail_cnt   = sat_add(r_fail_cnt, 32'd1);
                            n_out.status = STAT_NULL_FREE;
                        end else if (!r_hit) begin
                            n_fail_cnt   = sat_add(r_fail_cnt, 32'd1);
                            n_out.status = STAT_UNKNOWN;
                        end else if (!r_live[r_hit_idx]) begin
                            n_fail_cnt        = sat_add(r_fail_cnt, 32'd1);
                            n_out.status      = STAT_DOUBLE_FREE;
                            n_out.entry_index = 4'(r_hit_idx);
                        end else begin
                            n_live[r_hit_idx] = 1'b0;
                            n_ok_cnt          = sat_add(r_ok_cnt, 32'd1);
                            n_bytes_back      = sat_add(r_bytes_back, r_hit_size);
                            n_out.status      = STAT_FREED;
                            n_out.entry_index = 4'(r_hit_idx);
                        end
                    end
                    n_out.alloc_count     = n_alloc_cnt;
                    n_out.free_ok_count   = n_ok_cnt;
                    n_out.free_fail_count = n_fail_cnt;
                    n_out.bytes_allocated = n_bytes_out;
                    n_out.bytes_freed     = n_bytes_back;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/alct_checker.sv
// Port-level checker for the allocation tracker, bound to the top level.
`include "allocation_tracker_macros.svh"

module alct_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input alct_pkg::t_out_item o_out_item
);
    import alct_pkg::*;

    logic no_slot_status;

    // Outcomes that touch no slot
    assign no_slot_status = (o_out_item.status inside {STAT_NULL_FREE, STAT_UNKNOWN, STAT_FULL});

    // A pending result stays until taken
    `ALCT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid)

    // Reset drops any pending result
    `ALCT_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid)

    // The search keeps the input side closed right after an item is taken
    `ALCT_ASSERT(a_busy, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)

    // Outcomes that touch no slot report slot zero
    `ALCT_ASSERT(a_no_slot, i_clk, i_rst_n, (o_out_valid && no_slot_status) |-> (o_out_item.entry_index == 4'd0))

endmodule

bind allocation_tracker alct_checker u_alct_checker (.*);
